>>> sv/lhpt_pkg.sv
`default_nettype none

package lhpt_pkg;

   // Field widths
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 64;
   localparam int LIMIT_W = 8;
   localparam int COUNT_W = 9;
   localparam int HASH_W  = 30;

   localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 8'd192;

   // Response status codes
   typedef enum logic [1:0] {
      ST_HIT  = 2'd0,
      ST_MISS = 2'd1,
      ST_NEW  = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   // Request kinds
   typedef enum logic {
      MODE_LOOKUP = 1'b0,
      MODE_INSERT = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_MIX,
      FR_RECIP,
      FR_FOLD,
      FR_TRIM,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      EN_CLEAR,
      EN_IDLE,
      EN_PROBE
   } engine_state_type;

   // First half of the integer mix: add, xor, times 21 as shift-adds
   function automatic logic [31:0] mix_front(input logic [31:0] k);
      logic [31:0] h;
      h = ~k + (k << 18);
      h = h ^ (h >> 31);
      return h + (h << 2) + (h << 4);
   endfunction

   // Second half of the mix, masked to the hash width
   function automatic logic [HASH_W-1:0] mix_back(input logic [31:0] x);
      logic [31:0] h;
      h = x ^ (x >> 11);
      h = h + (h << 6);
      h = h ^ (h >> 22);
      return h[HASH_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/lhpt_req_if.sv
`default_nettype none

interface lhpt_req_if import lhpt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [KEY_W-1:0]   lookup_key;
   logic [VALUE_W-1:0] store_value;

   modport source (output valid, output mode, output lookup_key, output store_value,
                   input ready);
   modport sink   (input valid, input mode, input lookup_key, input store_value,
                   output ready);
endinterface

`default_nettype wire

>>> sv/lhpt_rsp_if.sv
`default_nettype none

interface lhpt_rsp_if import lhpt_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [VALUE_W-1:0] found_value;

   modport source (output valid, output status, output found_value, input ready);
   modport sink   (input valid, input status, input found_value, output ready);
endinterface

`default_nettype wire

>>> sv/lhpt_csr_if.sv
`default_nettype none

interface lhpt_csr_if import lhpt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] load_limit;

   modport source (output valid, output load_limit, input ready);
   modport sink   (input valid, input load_limit, output ready);
endinterface

`default_nettype wire

>>> sv/linear_probe_hash_table.sv
// Request path: hash, home slot reduction, a decoupling queue, then a probe walk and response;
//   a slot count that is not a power of two adds reciprocal, fold and trim steps.
// Hashing of the next request overlaps the probe walk, which reads one slot a cycle.
// Reset: a clearing pass over every slot empties the used bits, with req_ch.ready low;
//   load_limit returns to 192 and the entry count to zero.
`default_nettype none

module linear_probe_hash_table import lhpt_pkg::*; #(
   parameter int TABLE_SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   lhpt_req_if.sink    req_ch,
   lhpt_rsp_if.source  rsp_ch,
   lhpt_csr_if.sink    csr_ch
);

   localparam int IDX_W   = $clog2(TABLE_SLOTS);
   localparam int ENTRY_W = 1 + KEY_W + VALUE_W + IDX_W;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid, pop_ready;
   logic [ENTRY_W-1:0] pop_data;
   logic               clearing;

   // Hash and home slot
   lhpt_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Decoupling queue
   lhpt_queue #(.WIDTH(ENTRY_W), .DEPTH(2)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Probe walk, update and response
   lhpt_engine #(.TABLE_SLOTS(TABLE_SLOTS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch),
      .clearing  (clearing)
   );

endmodule

`default_nettype wire

>>> sv/lhpt_ram.sv
`default_nettype none

module lhpt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port (read returns old data)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/lhpt_queue.sv
`default_nettype none

module lhpt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/lhpt_front.sv
`default_nettype none

module lhpt_front import lhpt_pkg::*; #(
   parameter int TABLE_SLOTS = 256,
   localparam int IDX_W = $clog2(TABLE_SLOTS),
   localparam int ENTRY_W = 1 + KEY_W + VALUE_W + IDX_W
) (
   input  logic               clock,
   input  logic               reset,
   lhpt_req_if.sink           req_ch,
   input  logic               clearing,
   output logic               push_valid,
   input  logic               push_ready,
   output logic [ENTRY_W-1:0] push_data
);

   // Home slot reduction: mask for a power-of-two size, else a reciprocal
   // multiply for the quotient (low by at most one), a fold and a trim
   localparam bit POW2     = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   localparam int RECIP_SH = HASH_W + IDX_W;
   localparam int PROD_W   = 2 * HASH_W + 1;
   localparam int QUOT_W   = HASH_W + 1 - IDX_W;
   localparam logic [63:0] RECIP_WIDE = (64'd1 << RECIP_SH) / 64'(TABLE_SLOTS);
   localparam logic [HASH_W:0]   RECIP   = RECIP_WIDE[HASH_W:0];
   localparam logic [HASH_W-1:0] SLOTS_H = HASH_W'(TABLE_SLOTS);

   front_state_type    state_ff, state_in;
   logic               mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [31:0]        h_ff, h_in;
   logic [HASH_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [PROD_W-1:0]  recip_prod;

   // Quotient estimate by the scaled reciprocal
   assign recip_prod = PROD_W'(rem_ff) * PROD_W'(RECIP);

   // Next state and outputs
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      h_in         = h_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      req_ch.ready = 1'b0;
      push_valid   = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            req_ch.ready = !clearing;
            if (req_ch.valid && !clearing) begin
               mode_in  = req_ch.mode;
               key_in   = req_ch.lookup_key;
               value_in = req_ch.store_value;
               h_in     = mix_front(req_ch.lookup_key);
               state_in = FR_MIX;
            end
         end
         FR_MIX: begin
            rem_in   = mix_back(h_ff);
            state_in = POW2 ? FR_PUSH : FR_RECIP;
         end
         FR_RECIP: begin
            quot_in  = recip_prod[PROD_W-1 -: QUOT_W];
            state_in = FR_FOLD;
         end
         FR_FOLD: begin
            // remainder now below twice the slot count
            rem_in   = rem_ff - HASH_W'(quot_ff) * SLOTS_H;
            state_in = FR_TRIM;
         end
         FR_TRIM: begin
            if (rem_ff >= SLOTS_H) begin
               rem_in = rem_ff - SLOTS_H;
            end
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   assign push_data = {mode_ff, key_ff, value_ff, rem_ff[IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      key_ff   <= key_in;
      value_ff <= value_in;
      h_ff     <= h_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
   end

endmodule

`default_nettype wire

>>> sv/lhpt_engine.sv
`default_nettype none

module lhpt_engine import lhpt_pkg::*; #(
   parameter int TABLE_SLOTS = 256,
   localparam int IDX_W = $clog2(TABLE_SLOTS),
   localparam int ENTRY_W = 1 + KEY_W + VALUE_W + IDX_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  logic [ENTRY_W-1:0] pop_data,
   lhpt_csr_if.sink           csr_ch,
   lhpt_rsp_if.source         rsp_ch,
   output logic               clearing
);

   localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(TABLE_SLOTS - 1);

   engine_state_type   state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   clear_addr_ff, clear_addr_in;
   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [LIMIT_W-1:0] load_limit_ff, load_limit_in;
   logic               mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   // Queue entry fields
   logic               pop_mode;
   logic [KEY_W-1:0]   pop_key;
   logic [VALUE_W-1:0] pop_value;
   logic [IDX_W-1:0]   pop_home;
   assign {pop_mode, pop_key, pop_value, pop_home} = pop_data;

   // Memory ports
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               used_we, used_wdata, used_rd;
   logic [IDX_W-1:0]   used_waddr;
   logic               key_we, value_we;
   logic [KEY_W-1:0]   key_rd;
   logic [VALUE_W-1:0] value_rd;

   // Probe decision
   logic               hit, empty, last, done, out_free, room, finish;
   logic [IDX_W-1:0]   next_idx;

   assign hit      = used_rd && (key_rd == key_ff);
   assign empty    = !used_rd;
   assign last     = (count_ff == SLOT_LAST);
   assign done     = hit || empty || last;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign room     = (entry_count_ff < {1'b0, load_limit_ff});
   assign next_idx = (idx_ff == SLOT_LAST) ? '0 : idx_ff + IDX_W'(1);
   assign clearing = (state_ff == EN_CLEAR);

   // Next state, memory control and result
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      clear_addr_in  = clear_addr_ff;
      entry_count_in = entry_count_ff;
      mode_in        = mode_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      pop_ready      = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = idx_ff;
      used_we        = 1'b0;
      used_waddr     = idx_ff;
      used_wdata     = 1'b0;
      key_we         = 1'b0;
      value_we       = 1'b0;
      finish         = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      case (state_ff)
         EN_CLEAR: begin
            used_we       = 1'b1;
            used_waddr    = clear_addr_ff;
            clear_addr_in = (clear_addr_ff == SLOT_LAST) ? '0 : clear_addr_ff + IDX_W'(1);
            if (clear_addr_ff == SLOT_LAST) begin
               state_in = EN_IDLE;
            end
         end
         EN_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               rd_en    = 1'b1;
               rd_addr  = pop_home;
               idx_in   = pop_home;
               count_in = '0;
               mode_in  = pop_mode;
               key_in   = pop_key;
               value_in = pop_value;
               state_in = EN_PROBE;
            end
         end
         EN_PROBE: begin
            if (!done) begin
               // step to the next slot with wrap
               rd_en    = 1'b1;
               rd_addr  = next_idx;
               idx_in   = next_idx;
               count_in = count_ff + IDX_W'(1);
            end else if (out_free) begin
               finish       = 1'b1;
               state_in     = EN_IDLE;
               rsp_value_in = '0;
               if (mode_ff == MODE_LOOKUP) begin
                  if (hit) begin
                     rsp_status_in = ST_HIT;
                     rsp_value_in  = value_rd;
                  end else begin
                     rsp_status_in = ST_MISS;
                  end
               end else if (hit) begin
                  value_we      = 1'b1;
                  rsp_status_in = ST_HIT;
               end else if (empty && room) begin
                  used_we        = 1'b1;
                  used_wdata     = 1'b1;
                  key_we         = 1'b1;
                  value_we       = 1'b1;
                  entry_count_in = entry_count_ff + COUNT_W'(1);
                  rsp_status_in  = ST_NEW;
               end else begin
                  rsp_status_in = ST_FULL;
               end
            end
         end
         default: begin
            state_in = EN_IDLE;
         end
      endcase
   end

   // Output register
   assign rsp_valid_in       = finish || (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.found_value = rsp_value_ff;

   // Load limit register
   assign csr_ch.ready  = 1'b1;
   assign load_limit_in = csr_ch.valid ? csr_ch.load_limit : load_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= EN_CLEAR;
         clear_addr_ff  <= '0;
         entry_count_ff <= '0;
         load_limit_ff  <= LOAD_LIMIT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_addr_ff  <= clear_addr_in;
         entry_count_ff <= entry_count_in;
         load_limit_ff  <= load_limit_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      count_ff      <= count_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Slot stores
   lhpt_ram #(.WIDTH(1), .DEPTH(TABLE_SLOTS)) u_used_ram (
      .clock   (clock),
      .wr_en   (used_we),
      .wr_addr (used_waddr),
      .wr_data (used_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (used_rd)
   );

   lhpt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (idx_ff),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   lhpt_ram #(.WIDTH(VALUE_W), .DEPTH(TABLE_SLOTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (idx_ff),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (value_rd)
   );

`ifndef SYNTH
   // Load limit tops out at 255, so the count never reaches the top bit
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !entry_count_ff[COUNT_W-1])
      else $error("entry count out of range");

   // No response may appear while the used bits are being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == EN_CLEAR |-> !rsp_valid_ff)
      else $error("response during clearing pass");

   // Only a hit carries a value
   a_value_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_HIT |-> rsp_value_ff == '0)
      else $error("nonzero value on non-hit response");

   // A new key bumps the entry count by exactly one
   a_new_counts: assert property (@(posedge clock) disable iff (reset)
      finish && rsp_status_in == ST_NEW |=>
         entry_count_ff == $past(entry_count_ff) + COUNT_W'(1))
      else $error("entry count not advanced on insert");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

module tb_top;
   import lhpt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS    = 256;
   localparam int RESET_CYCLES   = 7;
   localparam int CYCLE_LIMIT    = 600000;
   // worst probe walk plus pipeline, for the quiet period at the end
   localparam int DRAIN_CYCLES   = TABLE_SLOTS + 40;
   localparam int HOLDOFF_AT     = 25;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int IDLE_PCT       = 20;

   // Random phases: load limit, request count, share of inserts
   localparam int NUM_PHASES = 4;
   localparam logic [LIMIT_W-1:0] PHASE_LIMIT [NUM_PHASES] = '{8'd40, 8'd128, 8'd255, 8'd1};
   localparam int PHASE_ITEMS  [NUM_PHASES] = '{90, 90, 160, 40};
   localparam int PHASE_INSERT [NUM_PHASES] = '{60, 50, 90, 50};

   typedef struct {
      status_type         status;
      logic [VALUE_W-1:0] value;
   } table_answer_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_LIMIT
   } row_kind_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [LIMIT_W-1:0] limit;
      mode_type           mode;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic               typed;
      status_type         status;
      logic [VALUE_W-1:0] answer;
   } stim_row_type;

   // Directed rows; typed answers only where obvious, the rest go through the predictor
   localparam int DIRECTED_COUNT = 24;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // empty table, extreme keys and values, update of a stored key
      '{ROW_REQUEST, 8'd0, MODE_LOOKUP, 32'h0000_0000, 64'h0, 1'b1, ST_MISS, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'h0000_0000, 64'h0, 1'b1, ST_NEW, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_LOOKUP, 32'h0000_0000, 64'h0, 1'b1, ST_HIT, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1,
        ST_NEW, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_LOOKUP, 32'hffff_ffff, 64'h0, 1'b1, ST_HIT,
        64'hffff_ffff_ffff_ffff},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'hffff_ffff, 64'h0123_4567_89ab_cdef, 1'b1,
        ST_HIT, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_LOOKUP, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1,
        ST_HIT, 64'h0123_4567_89ab_cdef},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000, 1'b1,
        ST_NEW, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_LOOKUP, 32'h0000_0001, 64'h0, 1'b1, ST_MISS, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'h0000_0001, 64'h1, 1'b1, ST_NEW, 64'h0},
      // limit reached: new key refused, stored key still updates
      '{ROW_LIMIT, 8'd4, MODE_LOOKUP, 32'h0, 64'h0, 1'b0, ST_HIT, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'hdead_beef, 64'h1111, 1'b1, ST_FULL, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'h0000_0000, 64'haaaa_aaaa_aaaa_aaaa, 1'b1,
        ST_HIT, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_LOOKUP, 32'h0000_0000, 64'h0, 1'b1, ST_HIT,
        64'haaaa_aaaa_aaaa_aaaa},
      '{ROW_REQUEST, 8'd0, MODE_LOOKUP, 32'hdead_beef, 64'h0, 1'b1, ST_MISS, 64'h0},
      // limit of zero
      '{ROW_LIMIT, 8'd0, MODE_LOOKUP, 32'h0, 64'h0, 1'b0, ST_HIT, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'h0000_0007, 64'h7, 1'b1, ST_FULL, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'h8000_0000, 64'h5555_5555_5555_5555, 1'b1,
        ST_HIT, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_LOOKUP, 32'h8000_0000, 64'h0, 1'b1, ST_HIT,
        64'h5555_5555_5555_5555},
      // highest limit
      '{ROW_LIMIT, 8'd255, MODE_LOOKUP, 32'h0, 64'h0, 1'b0, ST_HIT, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'hdead_beef, 64'hcafe_f00d_0000_0001, 1'b1,
        ST_NEW, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_INSERT, 32'h1234_5678, 64'h0f0f_f0f0_3c3c_c3c3, 1'b0,
        ST_HIT, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_LOOKUP, 32'h1234_5678, 64'h0, 1'b0, ST_HIT, 64'h0},
      '{ROW_REQUEST, 8'd0, MODE_LOOKUP, 32'h8000_0001, 64'h0, 1'b0, ST_HIT, 64'h0}
   };

   logic clock;
   logic reset;

   lhpt_req_if req_ch ();
   lhpt_rsp_if rsp_ch ();
   lhpt_csr_if csr_ch ();

   linear_probe_hash_table #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow copy of the table and its settings
   bit                 shadow_used  [TABLE_SLOTS];
   logic [KEY_W-1:0]   shadow_key   [TABLE_SLOTS];
   logic [VALUE_W-1:0] shadow_value [TABLE_SLOTS];
   int unsigned        shadow_count;
   logic [LIMIT_W-1:0] shadow_limit;
   logic [KEY_W-1:0]   resident_keys [$];

   table_answer_type expected_answers [$];
   int unsigned      error_count;
   int unsigned      answers_checked;
   int unsigned      items_sent;
   int unsigned      cycle_count;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Home slot: integer mix hash masked to 30 bits, then modulo the slot count
   function automatic int unsigned key_home_slot(input logic [KEY_W-1:0] key);
      logic [31:0] h;
      h = ~key + (key << 18);
      h = h ^ (h >> 31);
      h = h * 32'd21;
      h = h ^ (h >> 11);
      h = h + (h << 6);
      h = h ^ (h >> 22);
      return (h & 32'h3fff_ffff) % TABLE_SLOTS;
   endfunction

   // Walk the shadow table for one request and apply any insert or update
   function automatic table_answer_type lookup_or_store(input mode_type mode,
                                                        input logic [KEY_W-1:0] key,
                                                        input logic [VALUE_W-1:0] value);
      table_answer_type answer;
      int unsigned      slot;
      int               n;
      bit               key_found;
      bit               empty_found;
      slot        = key_home_slot(key);
      key_found   = 1'b0;
      empty_found = 1'b0;
      for (n = 0; n < TABLE_SLOTS; n++) begin
         if (!shadow_used[slot]) begin
            empty_found = 1'b1;
            break;
         end
         if (shadow_key[slot] == key) begin
            key_found = 1'b1;
            break;
         end
         slot = (slot + 1) % TABLE_SLOTS;
      end
      answer.value = '0;
      if (mode == MODE_LOOKUP) begin
         if (key_found) begin
            answer.status = ST_HIT;
            answer.value  = shadow_value[slot];
         end else begin
            answer.status = ST_MISS;
         end
      end else if (key_found) begin
         shadow_value[slot] = value;
         answer.status      = ST_HIT;
      end else if (empty_found && shadow_count < shadow_limit) begin
         shadow_used[slot]  = 1'b1;
         shadow_key[slot]   = key;
         shadow_value[slot] = value;
         shadow_count       = (shadow_count + 1) & 9'h1ff;
         resident_keys.push_back(key);
         answer.status      = ST_NEW;
      end else begin
         answer.status = ST_FULL;
      end
      return answer;
   endfunction

   // Offer one request, with random idle cycles ahead of it, and log its answer
   task automatic send_request(input mode_type mode, input logic [KEY_W-1:0] key,
                               input logic [VALUE_W-1:0] value, input bit typed,
                               input status_type typed_status,
                               input logic [VALUE_W-1:0] typed_value);
      table_answer_type answer;
      bool_idle_loop: while (!(items_sent >= 150 && items_sent < 260) &&
                             $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= mode;
      req_ch.lookup_key  <= key;
      req_ch.store_value <= value;
      do
         @(posedge clock);
      while (!req_ch.ready);
      answer = lookup_or_store(mode, key, value);
      if (typed) begin
         answer.status = typed_status;
         answer.value  = typed_value;
      end
      expected_answers.push_back(answer);
      items_sent++;
   endtask

   // Change the load limit once every outstanding transaction has come back
   task automatic write_load_limit(input logic [LIMIT_W-1:0] limit);
      req_ch.valid <= 1'b0;
      wait (expected_answers.size() == 0);
      @(posedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.load_limit <= limit;
      do
         @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      shadow_limit = limit;
   endtask

   // Request side: reset, directed rows, then random phases
   initial begin : request_source
      int                 phase;
      int                 n;
      int unsigned        pick;
      mode_type           mode;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      stim_row_type       row;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= MODE_LOOKUP;
      req_ch.lookup_key  <= '0;
      req_ch.store_value <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.load_limit  <= '0;
      for (n = 0; n < TABLE_SLOTS; n++) begin
         shadow_used[n] = 1'b0;
      end
      shadow_count    = 0;
      shadow_limit    = LOAD_LIMIT_RESET;
      error_count     = 0;
      items_sent      = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_COUNT; n++) begin
         row = DIRECTED_ROWS[n];
         if (row.kind == ROW_LIMIT) begin
            write_load_limit(row.limit);
         end else begin
            send_request(row.mode, row.key, row.value, row.typed, row.status, row.answer);
         end
      end

      // random content: keys from the stored set, the full range, or a narrow range
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         write_load_limit(PHASE_LIMIT[phase]);
         for (n = 0; n < PHASE_ITEMS[phase]; n++) begin
            mode = ($urandom_range(99) < PHASE_INSERT[phase]) ? MODE_INSERT : MODE_LOOKUP;
            pick = $urandom_range(9);
            if (pick < 4 && resident_keys.size() > 0) begin
               key = resident_keys[$urandom_range(resident_keys.size() - 1)];
            end else if (pick < 7) begin
               key = $urandom;
            end else begin
               key = $urandom_range(1023);
            end
            value = {$urandom, $urandom};
            send_request(mode, key, value, 1'b0, ST_HIT, '0);
         end
      end
      req_ch.valid <= 1'b0;

      wait (expected_answers.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Response side: check each transaction, idle at random, one long hold-off
   initial begin : answer_sink
      int unsigned      holdoff_left;
      bit               holdoff_done;
      table_answer_type want;
      holdoff_left    = 0;
      holdoff_done    = 1'b0;
      answers_checked = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
               error_count++;
               $error("unexpected transaction: status %0d found_value %h",
                      rsp_ch.status, rsp_ch.found_value);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_ch.status !== want.status) begin
                  error_count++;
                  $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               end
               if (rsp_ch.found_value !== want.value) begin
                  error_count++;
                  $error("found_value: expected %h, actual %h", want.value,
                         rsp_ch.found_value);
               end
            end
            answers_checked++;
         end
         // long hold-off so the block backs up into its input
         if (!holdoff_done && answers_checked >= HOLDOFF_AT) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ch.ready <= 1'b0;
         end else if (answers_checked >= 180 && answers_checked < 300) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog
   initial begin : cycle_watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire

>>> linear_probe_hash_table.f
sv/lhpt_pkg.sv
sv/lhpt_req_if.sv
sv/lhpt_rsp_if.sv
sv/lhpt_csr_if.sv
sv/lhpt_ram.sv
sv/lhpt_queue.sv
sv/lhpt_front.sv
sv/lhpt_engine.sv
sv/linear_probe_hash_table.sv
tb/sv/tb_top.sv
